### hdl/mfba_pkg.sv
`timescale 1ns / 1ps

package mfba_pkg;

    localparam int MAX_NODES = 64;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int NCNT_W    = NODE_W + 1;
    localparam int CAP_WIDTH = 16;
    localparam int RES_W     = CAP_WIDTH + 1;
    localparam int ADDR_W    = 2 * NODE_W;
    localparam int FLOW_W    = 22;
    localparam int CNT_W     = 16;

    localparam logic [RES_W-1:0]  RES_MAX   = {RES_W{1'b1}};
    localparam logic [FLOW_W-1:0] FLOW_MAX  = {FLOW_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_SOLVE = 2'd2;

    localparam logic [1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SOURCE_NODE = 2'd1;
    localparam logic [1:0] CFG_SINK_NODE   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] capacity;
    } in_req_t;

    typedef struct packed {
        logic [21:0] max_flow;
        logic [15:0] path_count;
    } out_rsp_t;

    // One-hot style command bits from the controller to the datapath.
    typedef struct packed {
        logic clr_start;
        logic clr_step;
        logic edge_wr;
        logic solve_start;
        logic bfs_init;
        logic q_rd;
        logic u_ld;
        logic s_rd;
        logic s_chk;
        logic walk_init;
        logic p_rd;
        logic f_rd;
        logic min_upd;
        logic b_rd;
        logic fwr;
        logic bwr;
        logic acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bad_terms;
        logic clr_last;
        logic q_empty;
        logic hit;
        logic v_last;
        logic u_is_src;
        logic out_free;
    } status_t;

endpackage

### hdl/mfba_ram.sv
`timescale 1ns / 1ps

module mfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mfba_ctrl.sv
`timescale 1ns / 1ps

module mfba_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       in_opcode,
    output logic             in_stall,
    input  mfba_pkg::status_t sts,
    output mfba_pkg::cmd_t    cmd
);

    import mfba_pkg::*;

    typedef enum logic [4:0] {
        ST_CLR, ST_IDLE, ST_BFS_INIT, ST_Q_CHK, ST_Q_RD, ST_U_LD, ST_S_RD, ST_S_CHK,
        ST_W1_INIT, ST_P1_RD, ST_F1_RD, ST_MIN, ST_W2_INIT, ST_P2_RD, ST_F2_RD,
        ST_B_RD, ST_FWR, ST_BWR, ST_ACC, ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_opcode)
                        OP_CLEAR:
                        begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLR;
                        end
                        OP_EDGE:
                        begin
                            cmd.edge_wr = 1'b1;
                        end
                        OP_SOLVE:
                        begin
                            cmd.solve_start = 1'b1;
                            state_next = sts.bad_terms ? ST_FINISH : ST_BFS_INIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BFS_INIT:
            begin
                cmd.bfs_init = 1'b1;
                state_next   = ST_Q_RD;
            end
            ST_Q_CHK:
            begin
                state_next = sts.q_empty ? ST_FINISH : ST_Q_RD;
            end
            ST_Q_RD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = ST_U_LD;
            end
            ST_U_LD:
            begin
                cmd.u_ld   = 1'b1;
                state_next = ST_S_RD;
            end
            ST_S_RD:
            begin
                cmd.s_rd   = 1'b1;
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                cmd.s_chk = 1'b1;
                if (sts.hit)
                begin
                    state_next = ST_W1_INIT;
                end
                else if (sts.v_last)
                begin
                    state_next = ST_Q_CHK;
                end
                else
                begin
                    state_next = ST_S_RD;
                end
            end
            ST_W1_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_P1_RD;
            end
            ST_P1_RD:
            begin
                cmd.p_rd   = 1'b1;
                state_next = ST_F1_RD;
            end
            ST_F1_RD:
            begin
                cmd.f_rd   = 1'b1;
                state_next = ST_MIN;
            end
            ST_MIN:
            begin
                cmd.min_upd = 1'b1;
                state_next  = sts.u_is_src ? ST_W2_INIT : ST_P1_RD;
            end
            ST_W2_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_P2_RD;
            end
            ST_P2_RD:
            begin
                cmd.p_rd   = 1'b1;
                state_next = ST_F2_RD;
            end
            ST_F2_RD:
            begin
                cmd.f_rd   = 1'b1;
                state_next = ST_B_RD;
            end
            ST_B_RD:
            begin
                cmd.b_rd   = 1'b1;
                state_next = ST_FWR;
            end
            ST_FWR:
            begin
                cmd.fwr    = 1'b1;
                state_next = ST_BWR;
            end
            ST_BWR:
            begin
                cmd.bwr    = 1'b1;
                state_next = sts.u_is_src ? ST_ACC : ST_P2_RD;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = ST_BFS_INIT;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/mfba_dp.sv
`timescale 1ns / 1ps

module mfba_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  mfba_pkg::cmd_t    cmd,
    output mfba_pkg::status_t sts,
    input  mfba_pkg::in_req_t in_req,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output mfba_pkg::out_rsp_t out_rsp
);

    import mfba_pkg::*;

    // Configuration.
    logic [NCNT_W-1:0] node_count_reg;
    logic [NODE_W-1:0] src_reg, snk_reg;

    // Search and walk state.
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [MAX_NODES-1:0] visited_reg;
    logic [NCNT_W-1:0]    head_reg, tail_reg;
    logic [NODE_W-1:0]    u_reg, v_reg, w_reg;
    logic [RES_W-1:0]     b_reg, rf_reg, rb_reg;
    logic [FLOW_W-1:0]    flow_reg;
    logic [CNT_W-1:0]     paths_reg;
    logic                 out_valid_reg;
    out_rsp_t             out_rsp_reg;

    logic [NCNT_W-1:0] n_eff;
    logic              scan_take;

    // Memory ports.
    logic              res_we;
    logic [ADDR_W-1:0] res_waddr, res_raddr;
    logic [RES_W-1:0]  res_wdata, res_rdata;
    logic              q_we, par_we;
    logic [NODE_W-1:0] q_waddr, q_wdata, q_raddr, q_rdata;
    logic [NODE_W-1:0] par_rdata;

    logic [RES_W:0]    back_sum;
    logic [FLOW_W:0]   flow_sum;

    assign n_eff = (node_count_reg > NCNT_W'(MAX_NODES)) ? NCNT_W'(MAX_NODES) : node_count_reg;
    assign scan_take = !visited_reg[v_reg] && (res_rdata != '0);
    assign back_sum  = {1'b0, rb_reg} + {1'b0, b_reg};
    assign flow_sum  = {1'b0, flow_reg} + (FLOW_W + 1)'(b_reg);

    always_comb
    begin
        sts.bad_terms = !(({1'b0, src_reg} < n_eff) && ({1'b0, snk_reg} < n_eff)
                          && (src_reg != snk_reg));
        sts.clr_last  = (clr_addr_reg == ADDR_LAST);
        sts.q_empty   = (head_reg == tail_reg);
        sts.hit       = scan_take && (v_reg == snk_reg);
        sts.v_last    = ({1'b0, v_reg} == (n_eff - NCNT_W'(1)));
        sts.u_is_src  = (u_reg == src_reg);
        sts.out_free  = !out_valid_reg || !out_stall;
    end

    // Residual port selection.
    always_comb
    begin
        res_we    = 1'b0;
        res_waddr = clr_addr_reg;
        res_wdata = '0;
        if (cmd.clr_step)
        begin
            res_we = 1'b1;
        end
        else if (cmd.edge_wr)
        begin
            res_we    = 1'b1;
            res_waddr = {in_req.from_node, in_req.to_node};
            res_wdata = {1'b0, in_req.capacity};
        end
        else if (cmd.fwr)
        begin
            res_we    = 1'b1;
            res_waddr = {u_reg, w_reg};
            res_wdata = rf_reg - b_reg;
        end
        else if (cmd.bwr)
        begin
            res_we    = 1'b1;
            res_waddr = {w_reg, u_reg};
            res_wdata = back_sum[RES_W] ? RES_MAX : back_sum[RES_W-1:0];
        end

        if (cmd.f_rd)
        begin
            res_raddr = {par_rdata, w_reg};
        end
        else if (cmd.b_rd)
        begin
            res_raddr = {w_reg, u_reg};
        end
        else
        begin
            res_raddr = {u_reg, v_reg};
        end
    end

    // Queue and parent ports.
    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = tail_reg[NODE_W-1:0];
        q_wdata = v_reg;
        if (cmd.bfs_init)
        begin
            q_we    = 1'b1;
            q_waddr = '0;
            q_wdata = src_reg;
        end
        else if (cmd.s_chk && scan_take && (v_reg != snk_reg) && !tail_reg[NODE_W])
        begin
            q_we = 1'b1;
        end
        q_raddr = head_reg[NODE_W-1:0];
        par_we  = cmd.s_chk && scan_take;
    end

    mfba_ram #(.WIDTH(RES_W), .DEPTH(MAX_NODES * MAX_NODES)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    mfba_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    mfba_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (v_reg),
        .wdata (u_reg),
        .raddr (w_reg),
        .rdata (par_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NCNT_W'(MAX_NODES);
            src_reg        <= '0;
            snk_reg        <= NODE_W'(1);
            clr_addr_reg   <= '0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            w_reg          <= '0;
            b_reg          <= '0;
            flow_reg       <= '0;
            paths_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NODE_COUNT:  node_count_reg <= cfg_data;
                    CFG_SOURCE_NODE: src_reg <= cfg_data[NODE_W-1:0];
                    CFG_SINK_NODE:   snk_reg <= cfg_data[NODE_W-1:0];
                    default:         node_count_reg <= node_count_reg;
                endcase
            end
            if (cmd.clr_start)
            begin
                clr_addr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (cmd.solve_start)
            begin
                flow_reg  <= '0;
                paths_reg <= '0;
            end
            if (cmd.bfs_init)
            begin
                visited_reg <= MAX_NODES'(1) << src_reg;
                head_reg    <= '0;
                tail_reg    <= NCNT_W'(1);
                b_reg       <= RES_MAX;
            end
            if (cmd.q_rd)
            begin
                head_reg <= head_reg + NCNT_W'(1);
            end
            if (cmd.u_ld)
            begin
                u_reg <= q_rdata;
                v_reg <= '0;
            end
            if (cmd.s_chk)
            begin
                if (scan_take)
                begin
                    visited_reg[v_reg] <= 1'b1;
                    if ((v_reg != snk_reg) && !tail_reg[NODE_W])
                    begin
                        tail_reg <= tail_reg + NCNT_W'(1);
                    end
                end
                v_reg <= v_reg + NODE_W'(1);
            end
            if (cmd.walk_init)
            begin
                w_reg <= snk_reg;
            end
            if (cmd.f_rd)
            begin
                u_reg <= par_rdata;
            end
            if (cmd.min_upd)
            begin
                if (res_rdata < b_reg)
                begin
                    b_reg <= res_rdata;
                end
                w_reg <= u_reg;
            end
            if (cmd.bwr)
            begin
                w_reg <= u_reg;
            end
            if (cmd.acc)
            begin
                flow_reg <= flow_sum[FLOW_W] ? FLOW_MAX : flow_sum[FLOW_W-1:0];
                if (paths_reg != COUNT_MAX)
                begin
                    paths_reg <= paths_reg + CNT_W'(1);
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.b_rd)
        begin
            rf_reg <= res_rdata;
        end
        if (cmd.fwr)
        begin
            rb_reg <= res_rdata;
        end
        if (cmd.out_load)
        begin
            out_rsp_reg.max_flow   <= flow_reg;
            out_rsp_reg.path_count <= paths_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

### hdl/max_flow_bfs_augment.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_stall    in_req  (opcode, from_node, to_node, capacity)
// out       result     out_valid / out_stall  out_rsp (max_flow, path_count)
// cfg       write      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A clear request writes one residual entry per cycle through the single write port
// of the residual memory; after reset the same clearing pass runs before the first
// request is taken. A solve runs searches until one fails; each search dequeues
// nodes and scans every node for each one, stopping early once the sink is reached,
// and each path found adds a bottleneck walk and then an update walk, both paced by
// the one read port of the residual memory. in_stall is high for the whole solve;
// the result waits in an output register, so out_stall only holds the controller
// once a second result is ready.

module max_flow_bfs_augment (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mfba_pkg::in_req_t in_req,
    output logic              out_valid,
    input  logic              out_stall,
    output mfba_pkg::out_rsp_t out_rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);

    import mfba_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // The user must write registers only while idle; the block itself does not enforce it, so the port is always ready.
    assign cfg_ready = 1'b1;

    mfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_req.opcode),
        .in_stall  (in_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mfba_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (in_req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import mfba_pkg::*;

    // The watchdog limit counts cycles with no accepted request or result.
    // The longest quiet stretch is one clear, the clearing pass after reset, or one
    // solve. Stimulus keeps dense graphs small so that only a few searches run per
    // solve, but the limit still allows generously.
    localparam int WATCHDOG_LIMIT = 4000000;
    localparam int DRAIN_CYCLES   = 5000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    in_req_t  in_req;
    logic     out_valid;
    logic     out_stall;
    out_rsp_t out_rsp;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    max_flow_bfs_augment u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: a private copy of the residual matrix and the registers.
    logic [RES_W-1:0] cap_matrix [MAX_NODES*MAX_NODES];
    logic [6:0]       cur_node_count;
    logic [5:0]       cur_source;
    logic [5:0]       cur_sink;

    out_rsp_t flow_results_due [$];
    int       error_count;
    int       quiet_cycles;
    bit       idle_enabled;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Breadth-first search over positive residuals. Fills the predecessor table
    // and returns 1 when the sink is reached. Node order and early exit at the
    // sink match the block, so ties in path choice resolve the same way.
    function automatic bit find_path(input int n, input int src, input int snk,
                                     ref int pred [MAX_NODES]);
        bit seen [MAX_NODES];
        int fifo [MAX_NODES];
        int head;
        int tail;
        int u;
        head = 0;
        tail = 0;
        for (int i = 0; i < MAX_NODES; i++)
            seen[i] = 1'b0;
        fifo[tail++] = src;
        seen[src] = 1'b1;
        pred[src] = src;
        while (head < tail)
        begin
            u = fifo[head++];
            for (int v = 0; v < n; v++)
            begin
                if (seen[v] || cap_matrix[u*MAX_NODES+v] == '0)
                    continue;
                seen[v] = 1'b1;
                pred[v] = u;
                if (v == snk)
                    return 1'b1;
                if (tail < MAX_NODES)
                    fifo[tail++] = v;
            end
        end
        return 1'b0;
    endfunction

    // Runs a whole solve on the predictor copy and returns the expected result.
    function automatic out_rsp_t solve_flow();
        out_rsp_t r;
        int pred [MAX_NODES];
        int n;
        int src;
        int snk;
        int u;
        int v;
        longint flow;
        longint paths;
        longint bn;
        longint back;
        n = (cur_node_count > MAX_NODES) ? MAX_NODES : cur_node_count;
        src = cur_source;
        snk = cur_sink;
        flow = 0;
        paths = 0;
        if (src < n && snk < n && src != snk)
        begin
            while (find_path(n, src, snk, pred))
            begin
                bn = RES_MAX;
                v = snk;
                while (v != src)
                begin
                    u = pred[v];
                    if (cap_matrix[u*MAX_NODES+v] < bn)
                        bn = cap_matrix[u*MAX_NODES+v];
                    v = u;
                end
                v = snk;
                while (v != src)
                begin
                    u = pred[v];
                    back = cap_matrix[v*MAX_NODES+u] + bn;
                    cap_matrix[u*MAX_NODES+v] = cap_matrix[u*MAX_NODES+v] - bn;
                    cap_matrix[v*MAX_NODES+u] = (back > RES_MAX) ? RES_MAX : back;
                    v = u;
                end
                flow += bn;
                if (flow > FLOW_MAX)
                    flow = FLOW_MAX;
                if (paths < COUNT_MAX)
                    paths++;
            end
        end
        r.max_flow = flow;
        r.path_count = paths;
        return r;
    endfunction

    // Applies one accepted request to the predictor.
    function automatic void predict_request(input in_req_t rq);
        case (rq.opcode)
            OP_CLEAR:
                for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
                    cap_matrix[i] = '0;
            OP_EDGE:
                cap_matrix[rq.from_node*MAX_NODES+rq.to_node] = {1'b0, rq.capacity};
            OP_SOLVE:
                flow_results_due.push_back(solve_flow());
            default:
                ;
        endcase
    endfunction

    function automatic bit should_idle();
        return idle_enabled && ($urandom_range(0, 99) < 18);
    endfunction

    // Sends one request and waits until it is accepted. Valid may drop for a
    // random gap between requests, but never within a held request. Valid stays
    // high after acceptance so that a following request can go back to back;
    // whoever next spends cycles without sending drops it first.
    task automatic send_request(input logic [1:0] op, input int a, input int b,
                                input int cap);
        in_req_t rq;
        rq.opcode = op;
        rq.from_node = a;
        rq.to_node = b;
        rq.capacity = cap;
        while (should_idle())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req <= rq;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_request(rq);
    endtask

    // Waits until every expected result is back and the block takes requests
    // again, then lets the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (flow_results_due.size() != 0 || in_stall)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_COUNT:  cur_node_count = val;
            CFG_SOURCE_NODE: cur_source = val;
            CFG_SINK_NODE:   cur_sink = val;
            default:         ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_terminals(input int n, input int src, input int snk);
        wait_idle();
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_SOURCE_NODE, src);
        write_reg(CFG_SINK_NODE, snk);
    endtask

    // Directed cases: extremes of each field, every opcode and the special cases.
    task automatic test_directed();
        set_terminals(64, 0, 1);
        send_request(OP_EDGE, 0, 1, 16'hFFFF);
        send_request(OP_EDGE, 0, 2, 5);
        send_request(OP_EDGE, 2, 1, 7);
        send_request(OP_EDGE, 3, 3, 9);      // self loop, no effect
        send_request(OP_EDGE, 63, 63, 1);
        send_request(2'd3, 63, 63, 16'hFFFF); // unused opcode
        send_request(OP_SOLVE, 0, 0, 0);
        send_request(OP_SOLVE, 0, 0, 0);     // repeated solve finds nothing left
        send_request(OP_EDGE, 0, 1, 0);      // zero capacity removes the edge
        send_request(OP_EDGE, 1, 0, 16'hFFFF); // overwrites the reverse residual
        send_request(OP_SOLVE, 0, 0, 0);
        // Sink beyond node count, then equal terminals, then a tiny graph and an empty one.
        set_terminals(4, 0, 5);
        send_request(OP_SOLVE, 0, 0, 0);
        set_terminals(4, 2, 2);
        send_request(OP_SOLVE, 0, 0, 0);
        set_terminals(1, 0, 1);
        send_request(OP_SOLVE, 0, 0, 0);
        set_terminals(0, 0, 0);
        send_request(OP_SOLVE, 0, 0, 0);
        // Edge beyond the node count is stored but unreachable until the count grows.
        send_request(OP_CLEAR, 0, 0, 0);
        set_terminals(2, 0, 1);
        send_request(OP_EDGE, 0, 5, 100);
        send_request(OP_EDGE, 5, 1, 100);
        send_request(OP_SOLVE, 0, 0, 0);
        set_terminals(127, 63, 1);
        send_request(OP_EDGE, 63, 0, 50);
        send_request(OP_SOLVE, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0);
    endtask

    // Reverse overflow: a path through a pair whose reverse residual is already
    // near the top saturates the reverse entry.
    task automatic test_reverse_saturation();
        set_terminals(3, 0, 2);
        send_request(OP_EDGE, 0, 1, 16'hFFFF);
        send_request(OP_EDGE, 1, 2, 16'hFFFF);
        send_request(OP_SOLVE, 0, 0, 0);
        send_request(OP_EDGE, 0, 1, 16'hFFFF); // reverse 1->0 now at 0xFFFF
        send_request(OP_EDGE, 1, 2, 16'hFFFF);
        send_request(OP_SOLVE, 0, 0, 0);
        send_request(OP_EDGE, 0, 1, 16'hFFFF); // reverse 1->0 now at 0x1FFFE
        send_request(OP_EDGE, 1, 2, 16'hFFFF);
        send_request(OP_SOLVE, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0);
    endtask

    // Random graphs: usually a clear, a burst of edges inside a small node count and
    // one or two solves. Some edges fall outside the count, some are noise.
    task automatic test_random_graphs(input int requests);
        int sent;
        int n;
        int k;
        sent = 0;
        while (sent < requests)
        begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(2, 64);
            else
                n = $urandom_range(2, 10);
            set_terminals(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SINK_NODE, $urandom_range(0, 63));
            if ($urandom_range(0, 4) != 0)
            begin
                send_request(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 65535));
                sent++;
            end
            k = (n > 16) ? $urandom_range(1, 40) : $urandom_range(1, 3 * n);
            for (int i = 0; i < k; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       send_request(2'd3, $urandom, $urandom, $urandom);
                    1:       send_request(OP_EDGE, $urandom_range(0, 63),
                                          $urandom_range(0, 63), $urandom_range(0, 65535));
                    2, 3:    send_request(OP_EDGE, $urandom_range(0, n - 1),
                                          $urandom_range(0, n - 1), 16'hFFFF - $urandom_range(0, 3));
                    default: send_request(OP_EDGE, $urandom_range(0, n - 1),
                                          $urandom_range(0, n - 1), $urandom_range(0, 65535));
                endcase
                sent++;
            end
            repeat ($urandom_range(1, 2))
            begin
                send_request(OP_SOLVE, $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // Result checker. Stall is redrawn every cycle; a result counts as taken at
    // an edge with valid high and stall low.
    always @(posedge clk)
    begin
        out_rsp_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                quiet_cycles <= 0;
                if (flow_results_due.size() == 0)
                begin
                    $display("%0t: unexpected result max_flow=%0d path_count=%0d",
                             $time, out_rsp.max_flow, out_rsp.path_count);
                    error_count++;
                end
                else
                begin
                    want = flow_results_due.pop_front();
                    if (out_rsp.max_flow !== want.max_flow)
                    begin
                        $display("%0t: max_flow expected %0d actual %0d",
                                 $time, want.max_flow, out_rsp.max_flow);
                        error_count++;
                    end
                    if (out_rsp.path_count !== want.path_count)
                    begin
                        $display("%0t: path_count expected %0d actual %0d",
                                 $time, want.path_count, out_rsp.path_count);
                        error_count++;
                    end
                end
            end
            else if (in_valid && !in_stall)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            out_stall <= should_idle();
        end
    end

    // Watchdog: a long run of cycles with nothing accepted means the block hung.
    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        error_count = 0;
        quiet_cycles = 0;
        idle_enabled = 1'b1;
        for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
            cap_matrix[i] = '0;
        cur_node_count = 64;
        cur_source = 0;
        cur_sink = 1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_reverse_saturation();
        // A stretch with no idling on either side.
        idle_enabled = 1'b0;
        test_random_graphs(300);
        idle_enabled = 1'b1;
        test_random_graphs(1350);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
hdl/mfba_pkg.sv
hdl/mfba_ram.sv
hdl/mfba_ctrl.sv
hdl/mfba_dp.sv
hdl/max_flow_bfs_augment.sv
test/testbench.sv
